// File: src/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants for the thrust to PWM curve: field widths, curve limits,
// register map and default breakpoints.
// ----------------------------------------------------------------------------
package tpc_pkg;

   // curve limits, timer ticks
   localparam int MEDIAN_DUTY    = 3000;
   localparam int HALF_RANGE_NEG = 600;
   localparam int HALF_RANGE_POS = 600;
   localparam int PWM_MIN        = 2400;
   localparam int PWM_MAX        = 3600;
   localparam int MOTOR_COUNT    = 6;

   localparam int PWM_LO     = MEDIAN_DUTY - HALF_RANGE_NEG;
   localparam int PWM_HI     = MEDIAN_DUTY + HALF_RANGE_POS;
   localparam int MIRROR_SUM = 2 * MEDIAN_DUTY;

   // field widths
   localparam int MOTOR_W  = 3;
   localparam int THRUST_W = 16;
   localparam int PWM_W    = 12;

   // datapath widths
   localparam int Y_W    = 16;             // Q12.4 curve ordinate
   localparam int SPAN_W = 16;
   localparam int PROD_W = Y_W + SPAN_W;
   localparam int REM_W  = PROD_W + 1;
   localparam int DEN_W  = SPAN_W + 4;
   localparam int QUO_W  = 13;             // quotient stays below 2^(Y_W-4) + 1

   localparam logic [Y_W-1:0] Y_LO = Y_W'(PWM_LO * 16);
   localparam logic [Y_W-1:0] Y_HI = Y_W'(PWM_HI * 16);

   // motors driven in reverse
   localparam logic [MOTOR_W-1:0] MIRROR_MOTOR_A = 3'd0;
   localparam logic [MOTOR_W-1:0] MIRROR_MOTOR_B = 3'd2;

   // register map
   localparam int CFG_W     = 16;
   localparam int CFG_COUNT = 8;
   localparam int CFG_IDX_W = $clog2(CFG_COUNT);
   localparam int ADDR_W    = CFG_IDX_W + 2;
   localparam int DATA_W    = 32;

   localparam logic [CFG_IDX_W-1:0] REG_THRUST_POINT_0 = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_THRUST_POINT_1 = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_THRUST_POINT_2 = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_THRUST_POINT_3 = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_PWM_POINT_0    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_PWM_POINT_1    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_PWM_POINT_2    = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_PWM_POINT_3    = 3'd7;

   localparam logic [CFG_W-1:0] CFG_RESET [CFG_COUNT] = '{
      16'hBD69, 16'hE93B, 16'h1111, 16'h3DE2,
      16'hA162, 16'hB860, 16'hBEA0, 16'hD0A1
   };

endpackage

// File: src/thrust_to_pwm_curve.sv
// ----------------------------------------------------------------------------
// thrust_to_pwm_curve
// Maps a signed Q12.4 thrust request onto a thruster PWM compare value
// through one shared piecewise linear curve.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_* carries a motor index and a thrust demand; the
//   result channel rsp_* returns the echoed index and the compare value.
//   Both use valid/stall; a transfer happens when valid is high and stall low.
//   The curve breakpoints sit behind the csr_* port, one 16-bit register per
//   word; write them only while no request is in flight.
//   A request passes from accept to rsp_valid through segment select,
//   operand select, two multipliers, numerator sum, a 13-stage restoring
//   divider (one quotient bit per stage) and the clamp/mirror output stage.
//   Throughput is one request per cycle while req_stall is low.
//   Reset empties the pipeline and loads the default curve.
//   While the receiver stalls, the result holds and the stages behind it keep
//   moving until every stage is full; only then is req_stall raised.
// ----------------------------------------------------------------------------
module thrust_to_pwm_curve (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tpc_pkg::MOTOR_W-1:0]         req_motor_index,
   input  logic signed [tpc_pkg::THRUST_W-1:0] req_thrust_demand,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tpc_pkg::MOTOR_W-1:0]         rsp_motor_tag,
   output logic [tpc_pkg::PWM_W-1:0]           rsp_pwm_compare,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tpc_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [tpc_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [tpc_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import tpc_pkg::*;

   typedef enum logic [2:0] {
      SEG_MEDIAN,
      SEG_FLOOR,
      SEG_RISE,
      SEG_NEG,
      SEG_POS,
      SEG_TOP,
      SEG_CEIL
   } seg_type;

   localparam int NS    = QUO_W + 6;
   localparam int DIV_0 = 4;

   // configuration
   logic [CFG_W-1:0] cfg_ff [CFG_COUNT];
   logic             cfg_we;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = DATA_W'(cfg_ff[csr_paddr[ADDR_W-1:2]]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_COUNT; i++) cfg_ff[i] <= CFG_RESET[i];
      end else if (cfg_we) begin
         cfg_ff[csr_paddr[ADDR_W-1:2]] <= csr_pwdata[CFG_W-1:0];
      end
   end

   logic signed [THRUST_W-1:0] tp0, tp1, tp2, tp3;
   logic [Y_W-1:0]             pp0, pp1, pp2, pp3;

   assign tp0 = $signed(cfg_ff[REG_THRUST_POINT_0]);
   assign tp1 = $signed(cfg_ff[REG_THRUST_POINT_1]);
   assign tp2 = $signed(cfg_ff[REG_THRUST_POINT_2]);
   assign tp3 = $signed(cfg_ff[REG_THRUST_POINT_3]);
   assign pp0 = cfg_ff[REG_PWM_POINT_0];
   assign pp1 = cfg_ff[REG_PWM_POINT_1];
   assign pp2 = cfg_ff[REG_PWM_POINT_2];
   assign pp3 = cfg_ff[REG_PWM_POINT_3];

   // pipeline control
   logic [NS-1:0] v_ff, v_in, ld;

   assign v_in = {v_ff[NS-2:0], req_valid};

   for (genvar i = 0; i < NS; i++) begin : g_ld
      assign ld[i] = !rsp_stall || !(&v_ff[NS-1:i]);
   end

   assign req_stall = !ld[0];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (ld[i]) v_ff[i] <= v_in[i];
         end
      end
   end

   // stage 1: request
   logic [MOTOR_W-1:0]         s1_motor_ff;
   logic signed [THRUST_W-1:0] s1_thrust_ff;

   // segment select
   seg_type s2_seg_in;

   always_comb begin
      if (s1_thrust_ff == '0)      s2_seg_in = SEG_MEDIAN;
      else if (s1_thrust_ff <= tp0) s2_seg_in = SEG_FLOOR;
      else if (s1_thrust_ff <= tp1) s2_seg_in = SEG_RISE;
      else if (s1_thrust_ff[THRUST_W-1]) s2_seg_in = SEG_NEG;
      else if (s1_thrust_ff <= tp2) s2_seg_in = SEG_POS;
      else if (s1_thrust_ff < tp3)  s2_seg_in = SEG_TOP;
      else                          s2_seg_in = SEG_CEIL;
   end

   // stage 2
   logic [MOTOR_W-1:0]         s2_motor_ff;
   logic signed [THRUST_W-1:0] s2_thrust_ff;
   seg_type                    s2_seg_ff;

   logic signed [THRUST_W-1:0] sx, ex;
   logic signed [THRUST_W:0]   span_wide, rest_wide, dt_wide;
   logic [Y_W-1:0]             sy, ey;

   always_comb begin
      case (s2_seg_ff)
         SEG_RISE: begin
            sx = tp0; ex = tp1; sy = Y_LO; ey = pp0;
         end
         SEG_NEG: begin
            sx = tp1; ex = '0;  sy = pp0;  ey = pp1;
         end
         SEG_POS: begin
            sx = '0;  ex = tp2; sy = pp2;  ey = pp3;
         end
         SEG_TOP: begin
            sx = tp2; ex = tp3; sy = pp3;  ey = Y_HI;
         end
         default: begin
            sx = '0;  ex = '0;  sy = '0;   ey = '0;
         end
      endcase
      span_wide = ex - sx;
      rest_wide = ex - s2_thrust_ff;
      dt_wide   = s2_thrust_ff - sx;
   end

   // stage 3
   logic [MOTOR_W-1:0] s3_motor_ff;
   seg_type            s3_seg_ff;
   logic [Y_W-1:0]     s3_sy_ff, s3_ey_ff;
   logic [SPAN_W-1:0]  s3_span_ff, s3_rest_ff, s3_dt_ff;

   // stage 4: weighted ordinates
   logic [MOTOR_W-1:0] s4_motor_ff;
   seg_type            s4_seg_ff;
   logic [PROD_W-1:0]  s4_pa_ff, s4_pb_ff;
   logic [SPAN_W-1:0]  s4_span_ff;

   // divider stages, index 0 holds the rounded numerator
   logic [MOTOR_W-1:0] d_motor_ff [QUO_W+1];
   seg_type            d_seg_ff   [QUO_W+1];
   logic [REM_W-1:0]   d_rem_ff   [QUO_W+1];
   logic [DEN_W-1:0]   d_den_ff   [QUO_W+1];
   logic [QUO_W-1:0]   d_quo_ff   [QUO_W+1];

   logic [MOTOR_W-1:0] d_motor_in [QUO_W+1];
   seg_type            d_seg_in   [QUO_W+1];
   logic [REM_W-1:0]   d_rem_in   [QUO_W+1];
   logic [DEN_W-1:0]   d_den_in   [QUO_W+1];
   logic [QUO_W-1:0]   d_quo_in   [QUO_W+1];

   always_comb begin
      logic [REM_W-1:0] trial;
      d_motor_in[0] = s4_motor_ff;
      d_seg_in[0]   = s4_seg_ff;
      d_rem_in[0]   = REM_W'(s4_pa_ff) + REM_W'(s4_pb_ff) + (REM_W'(s4_span_ff) << 3);
      d_den_in[0]   = {s4_span_ff, 4'b0000};
      d_quo_in[0]   = '0;
      for (int k = 1; k <= QUO_W; k++) begin
         trial         = REM_W'(d_den_ff[k-1]) << (QUO_W - k);
         d_motor_in[k] = d_motor_ff[k-1];
         d_seg_in[k]   = d_seg_ff[k-1];
         d_den_in[k]   = d_den_ff[k-1];
         if (d_rem_ff[k-1] >= trial) begin
            d_rem_in[k] = d_rem_ff[k-1] - trial;
            d_quo_in[k] = d_quo_ff[k-1] | (QUO_W'(1) << (QUO_W - k));
         end else begin
            d_rem_in[k] = d_rem_ff[k-1];
            d_quo_in[k] = d_quo_ff[k-1];
         end
      end
   end

   // output stage: pick, clamp, mirror, clamp
   logic [QUO_W-1:0]   raw, lim, mir, fin;
   logic [MOTOR_W-1:0] last_motor;

   assign last_motor = d_motor_ff[QUO_W];

   always_comb begin
      case (d_seg_ff[QUO_W])
         SEG_MEDIAN: raw = QUO_W'(MEDIAN_DUTY);
         SEG_FLOOR:  raw = QUO_W'(PWM_LO);
         SEG_CEIL:   raw = QUO_W'(PWM_HI);
         default:    raw = d_quo_ff[QUO_W];
      endcase
      if (raw < QUO_W'(PWM_MIN))      lim = QUO_W'(PWM_MIN);
      else if (raw > QUO_W'(PWM_MAX)) lim = QUO_W'(PWM_MAX);
      else                            lim = raw;
      mir = QUO_W'(MIRROR_SUM) - lim;
      if (last_motor < MOTOR_W'(MOTOR_COUNT) &&
          (last_motor inside {MIRROR_MOTOR_A, MIRROR_MOTOR_B})) begin
         if (mir < QUO_W'(PWM_MIN))      fin = QUO_W'(PWM_MIN);
         else if (mir > QUO_W'(PWM_MAX)) fin = QUO_W'(PWM_MAX);
         else                            fin = mir;
      end else begin
         fin = lim;
      end
   end

   logic [MOTOR_W-1:0] rsp_motor_ff;
   logic [PWM_W-1:0]   rsp_pwm_ff;

   assign rsp_motor_tag   = rsp_motor_ff;
   assign rsp_pwm_compare = rsp_pwm_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s1_motor_ff  <= req_motor_index;
         s1_thrust_ff <= req_thrust_demand;
      end
      if (ld[1]) begin
         s2_motor_ff  <= s1_motor_ff;
         s2_thrust_ff <= s1_thrust_ff;
         s2_seg_ff    <= s2_seg_in;
      end
      if (ld[2]) begin
         s3_motor_ff <= s2_motor_ff;
         s3_seg_ff   <= s2_seg_ff;
         s3_sy_ff    <= sy;
         s3_ey_ff    <= ey;
         s3_span_ff  <= span_wide[SPAN_W-1:0];
         s3_rest_ff  <= rest_wide[SPAN_W-1:0];
         s3_dt_ff    <= dt_wide[SPAN_W-1:0];
      end
      if (ld[3]) begin
         s4_motor_ff <= s3_motor_ff;
         s4_seg_ff   <= s3_seg_ff;
         s4_pa_ff    <= s3_sy_ff * s3_rest_ff;
         s4_pb_ff    <= s3_ey_ff * s3_dt_ff;
         s4_span_ff  <= s3_span_ff;
      end
      for (int k = 0; k <= QUO_W; k++) begin
         if (ld[DIV_0 + k]) begin
            d_motor_ff[k] <= d_motor_in[k];
            d_seg_ff[k]   <= d_seg_in[k];
            d_rem_ff[k]   <= d_rem_in[k];
            d_den_ff[k]   <= d_den_in[k];
            d_quo_ff[k]   <= d_quo_in[k];
         end
      end
      if (ld[NS-1]) begin
         rsp_motor_ff <= last_motor;
         rsp_pwm_ff   <= fin[PWM_W-1:0];
      end
   end

endmodule

// File: src/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks for the thrust to PWM curve, bound to the top level.
// ----------------------------------------------------------------------------
module tpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [tpc_pkg::MOTOR_W-1:0]         rsp_motor_tag,
   input logic [tpc_pkg::PWM_W-1:0]           rsp_pwm_compare
);
   import tpc_pkg::*;

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty output stage never back-pressures the request side
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // result within the timer range
   a_pwm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pwm_compare >= PWM_W'(PWM_MIN) &&
                     rsp_pwm_compare <= PWM_W'(PWM_MAX)))
      else $error("compare value out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pwm_compare) &&
                                 $stable(rsp_motor_tag))
      else $error("stalled result changed");

endmodule

bind thrust_to_pwm_curve tpc_checker u_tpc_checker (.*);

// File: sim/thrust_to_pwm_curve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrust_to_pwm_curve_checker
// Watches the request, result and register ports of the thrust to PWM curve.
// It keeps its own copy of the curve registers from the writes it sees on the
// register port. For every accepted request it works out the compare value
// with exact integer arithmetic and queues it. Each accepted result is then
// compared, field by field, with the oldest queued value.
// ----------------------------------------------------------------------------
module thrust_to_pwm_curve_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [tpc_pkg::MOTOR_W-1:0]         req_motor_index,
   input  logic signed [tpc_pkg::THRUST_W-1:0] req_thrust_demand,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [tpc_pkg::MOTOR_W-1:0]         rsp_motor_tag,
   input  logic [tpc_pkg::PWM_W-1:0]           rsp_pwm_compare,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [tpc_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [tpc_pkg::DATA_W-1:0]          csr_pwdata,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  request_count,
   output int                                  result_count
);
   import tpc_pkg::*;

   typedef struct packed {
      logic [MOTOR_W-1:0] motor_tag;
      logic [PWM_W-1:0]   pwm_compare;
   } pwm_result_type;

   logic [CFG_W-1:0] curve_regs [CFG_COUNT];
   pwm_result_type   pwm_expected_q [$];
   pwm_result_type   oldest;
   int               errors = 0;
   int               requests_seen = 0;
   int               results_seen = 0;

   initial begin
      fail_count    = 0;
      pending       = 0;
      request_count = 0;
      result_count  = 0;
   end

   function automatic longint div_floor(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den != 0) && ((num < 0) != (den < 0))) q = q - 1;
      return q;
   endfunction

   // y in Q12.4, result rounded half up to whole ticks
   function automatic longint segment_ticks(input longint x0, input longint x1,
                                            input longint y0, input longint y1,
                                            input longint t);
      longint span;
      span = x1 - x0;
      if (span <= 0) return div_floor(2 * y0 + 16, 32);
      return div_floor(2 * (y0 * span + (y1 - y0) * (t - x0)) + 16 * span, 32 * span);
   endfunction

   function automatic longint clamp_ticks(input longint v);
      if (v < PWM_MIN) return PWM_MIN;
      if (v > PWM_MAX) return PWM_MAX;
      return v;
   endfunction

   function automatic pwm_result_type curve_pwm(input logic [MOTOR_W-1:0] motor,
                                                input logic signed [THRUST_W-1:0] thrust);
      longint         t, bp0, bp1, bp2, bp3, pw0, pw1, pw2, pw3, ticks;
      pwm_result_type r;
      t   = thrust;
      bp0 = $signed(curve_regs[REG_THRUST_POINT_0]);
      bp1 = $signed(curve_regs[REG_THRUST_POINT_1]);
      bp2 = $signed(curve_regs[REG_THRUST_POINT_2]);
      bp3 = $signed(curve_regs[REG_THRUST_POINT_3]);
      pw0 = curve_regs[REG_PWM_POINT_0];
      pw1 = curve_regs[REG_PWM_POINT_1];
      pw2 = curve_regs[REG_PWM_POINT_2];
      pw3 = curve_regs[REG_PWM_POINT_3];
      if (t == 0) begin
         ticks = MEDIAN_DUTY;
      end else if (t <= bp0) begin
         ticks = PWM_LO;
      end else if (t <= bp1) begin
         ticks = segment_ticks(bp0, bp1, PWM_LO * 16, pw0, t);
      end else if (t <= 0) begin
         ticks = segment_ticks(bp1, 0, pw0, pw1, t);
      end else if (t <= bp2) begin
         ticks = segment_ticks(0, bp2, pw2, pw3, t);
      end else if (t < bp3) begin
         ticks = segment_ticks(bp2, bp3, pw3, PWM_HI * 16, t);
      end else begin
         ticks = PWM_HI;
      end
      ticks = clamp_ticks(ticks);
      // reversed thrusters
      if (motor == MIRROR_MOTOR_A || motor == MIRROR_MOTOR_B) begin
         ticks = clamp_ticks(MIRROR_SUM - ticks);
      end
      r.motor_tag   = motor;
      r.pwm_compare = ticks[PWM_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         curve_regs = CFG_RESET;
         pwm_expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            curve_regs[csr_paddr[ADDR_W-1:2]] = csr_pwdata[CFG_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pwm_expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result motor_tag %0d pwm_compare %0d, none expected",
                        $time, rsp_motor_tag, rsp_pwm_compare);
            end else begin
               oldest = pwm_expected_q.pop_front();
               if (oldest.motor_tag !== rsp_motor_tag) begin
                  errors++;
                  $display("%0t: motor_tag mismatch, expected %0d actual %0d",
                           $time, oldest.motor_tag, rsp_motor_tag);
               end
               if (oldest.pwm_compare !== rsp_pwm_compare) begin
                  errors++;
                  $display("%0t: pwm_compare mismatch (motor %0d), expected %0d actual %0d",
                           $time, oldest.motor_tag, oldest.pwm_compare, rsp_pwm_compare);
               end
            end
         end
         if (req_valid && !req_stall) begin
            requests_seen++;
            pwm_expected_q.push_back(curve_pwm(req_motor_index, req_thrust_demand));
         end
      end
      fail_count    <= errors;
      pending       <= pwm_expected_q.size();
      request_count <= requests_seen;
      result_count  <= results_seen;
   end

endmodule

// File: sim/tb_thrust_to_pwm_curve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thrust_to_pwm_curve
// Drives thrust requests into the curve block under a series of curve
// settings: the reset curve, spread and extreme breakpoints, misordered
// breakpoints and random curves. Each setting gets probes at and around
// every breakpoint, then random requests biased toward the breakpoints.
// Requests come in bursts with random gaps while the result side stalls on
// changing patterns. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_thrust_to_pwm_curve;
   import tpc_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PER_SET = 260;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [MOTOR_W-1:0]          req_motor_index = '0;
   logic signed [THRUST_W-1:0]  req_thrust_demand = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [MOTOR_W-1:0]          rsp_motor_tag;
   logic [PWM_W-1:0]            rsp_pwm_compare;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]           csr_paddr = '0;
   logic [DATA_W-1:0]           csr_pwdata = '0;
   logic [DATA_W-1:0]           csr_prdata;
   logic                        csr_pready;

   int                          fail_count;
   int                          pending;
   int                          request_count;
   int                          result_count;
   int                          quiet_cycles = 0;
   int                          burst_left = 0;
   int                          curve_sets = 0;
   logic [CFG_W-1:0]            curve_cfg [CFG_COUNT];

   always #(CLK_PERIOD / 2) clock = ~clock;

   thrust_to_pwm_curve i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_motor_index   (req_motor_index),
      .req_thrust_demand (req_thrust_demand),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_tag     (rsp_motor_tag),
      .rsp_pwm_compare   (rsp_pwm_compare),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   thrust_to_pwm_curve_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_motor_index   (req_motor_index),
      .req_thrust_demand (req_thrust_demand),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_tag     (rsp_motor_tag),
      .rsp_pwm_compare   (rsp_pwm_compare),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_pready        (csr_pready),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .fail_count        (fail_count),
      .pending           (pending),
      .request_count     (request_count),
      .result_count      (result_count)
   );

   task automatic send_request(input logic [MOTOR_W-1:0] motor,
                               input logic [THRUST_W-1:0] thrust);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 24) : $urandom_range(60, 200);
      end
      req_valid         <= 1'b1;
      req_motor_index   <= motor;
      req_thrust_demand <= thrust;
      burst_left--;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every result
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_curve_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'($urandom), 16'(value)};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      curve_cfg[idx] = 16'(value);
   endtask

   task automatic program_curve(input int tp0, input int tp1, input int tp2, input int tp3,
                                input int pp0, input int pp1, input int pp2, input int pp3);
      settle();
      write_curve_reg(REG_PWM_POINT_3, pp3);
      write_curve_reg(REG_THRUST_POINT_0, tp0);
      write_curve_reg(REG_PWM_POINT_1, pp1);
      write_curve_reg(REG_THRUST_POINT_2, tp2);
      write_curve_reg(REG_PWM_POINT_0, pp0);
      write_curve_reg(REG_THRUST_POINT_3, tp3);
      write_curve_reg(REG_PWM_POINT_2, pp2);
      write_curve_reg(REG_THRUST_POINT_1, tp1);
   endtask

   // zero, +/-1, full scale, on/just past the first three breakpoints, just before/on the last
   task automatic run_breakpoint_probes();
      logic [THRUST_W-1:0] probe [13];
      probe = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                curve_cfg[REG_THRUST_POINT_0], curve_cfg[REG_THRUST_POINT_0] + 16'd1,
                curve_cfg[REG_THRUST_POINT_1], curve_cfg[REG_THRUST_POINT_1] + 16'd1,
                curve_cfg[REG_THRUST_POINT_2], curve_cfg[REG_THRUST_POINT_2] + 16'd1,
                curve_cfg[REG_THRUST_POINT_3] - 16'd1, curve_cfg[REG_THRUST_POINT_3]};
      curve_sets++;
      foreach (probe[i]) send_request(MOTOR_W'((i + curve_sets) % 8), probe[i]);
   endtask

   task automatic run_random_requests(input int count);
      int                  pick;
      logic [THRUST_W-1:0] thrust;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            thrust = 16'($urandom);
         end else if (pick < 80) begin
            thrust = 16'(curve_cfg[$urandom_range(0, 3)] + $urandom_range(0, 8) - 4);
         end else if (pick < 92) begin
            thrust = 16'($urandom_range(0, 32) - 16);
         end else begin
            case ($urandom_range(0, 2))
               0: thrust = 16'h0000;
               1: thrust = 16'h8000;
               default: thrust = 16'h7FFF;
            endcase
         end
         send_request(MOTOR_W'($urandom_range(0, 7)), thrust);
      end
   endtask

   // result side back-pressure
   initial begin
      stall_mode_type mode;
      int             span;
      int             tick;
      tick = 0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(50, 400);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
               default:     rsp_stall <= ((tick % 7) >= 4);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending);
      $display("tb_thrust_to_pwm_curve: FAIL");
      $finish;
   end

   initial begin
      curve_cfg = CFG_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_breakpoint_probes();
      run_random_requests(RANDOM_PER_SET);

      program_curve(-20000, -8000, 6000, 20000, 40000, 46000, 50000, 56000);
      run_breakpoint_probes();
      run_random_requests(RANDOM_PER_SET);

      // full scale breakpoints, pwm points at both rails
      program_curve(-32768, -1, 1, 32767, 0, 65535, 0, 65535);
      run_breakpoint_probes();
      run_random_requests(RANDOM_PER_SET);

      // one segment spanning almost the whole range
      program_curve(-32768, 32767, 32767, 32767, 65535, 0, 65535, 0);
      run_breakpoint_probes();
      run_random_requests(RANDOM_PER_SET);

      // misordered breakpoints
      program_curve(-20000, 5000, -100, -50, 30000, 60000, 20000, 45000);
      run_breakpoint_probes();
      run_random_requests(RANDOM_PER_SET);

      repeat (2) begin
         int neg_knee, pos_knee;
         neg_knee = -$urandom_range(1, 20000);
         pos_knee = $urandom_range(1, 20000);
         program_curve(neg_knee - $urandom_range(1, 12000), neg_knee, pos_knee,
                       pos_knee + $urandom_range(1, 12000), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
         run_breakpoint_probes();
         run_random_requests(RANDOM_PER_SET);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results over %0d curve settings", request_count,
               result_count, curve_sets);
      $display("settings included rail and misordered breakpoints, all motor indexes");
      if (fail_count == 0) begin
         $display("tb_thrust_to_pwm_curve: PASS");
      end else begin
         $display("tb_thrust_to_pwm_curve: FAIL");
      end
      $finish;
   end

endmodule

// File: thrust_to_pwm_curve.f
src/tpc_pkg.sv
src/thrust_to_pwm_curve.sv
src/tpc_checker.sv
sim/thrust_to_pwm_curve_checker.sv
sim/tb_thrust_to_pwm_curve.sv
